>>> src/fbpa_pkg.sv
// Package for the fixed block pool allocator: command and status codes,
// register indexes, field widths, reset values and layout constants.
// No dependencies.
package fbpa_pkg;

   // Default pool depth; the top level takes it as a parameter.
   localparam int MAX_BLOCKS_DEFAULT = 256;

   // Each block holds a 16-byte header, then the object, then an 8-byte trailer.
   localparam int HDR_BYTES      = 16;
   localparam int OVERHEAD_BYTES = 24;

   // Field widths.
   localparam int CMD_W         = 2;
   localparam int OFFSET_W      = 21;
   localparam int HIDX_W        = 16;
   localparam int STATUS_W      = 2;
   localparam int BIDX_W        = 8;
   localparam int INUSE_W       = 9;
   localparam int OBJECT_SIZE_W = 13;
   localparam int BCOUNT_W      = 9;
   localparam int STRIDE_W      = 14;
   localparam int PROD_W        = HIDX_W + STRIDE_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [OBJECT_SIZE_W-1:0] OBJECT_SIZE_RESET = 13'd64;
   localparam logic [BCOUNT_W-1:0]      BCOUNT_RESET      = 9'd256;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_POOL_FULL = 2'd2,
      ST_BAD_ADDR  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      REG_OBJECT_SIZE = 1'b0,
      REG_BLOCK_COUNT = 1'b1
   } reg_index_type;

endpackage

>>> src/fixed_block_pool_allocator_unit.sv
// Top level of the fixed block pool allocator: request register, ring control,
// offset arithmetic, result register and APB-style register port.
// Depends on fbpa_pkg and fbpa_ram.

// The allocator manages a pool of equal blocks through a FIFO ring of free
// block indices, which after reset, a reinitialize request or a write of
// block_count holds 0 to count-1 in order, where count is the smaller of
// block_count and MAX_BLOCKS. An allocate request takes the oldest free index
// and returns it with the object byte offset index*stride+16, where stride is
// object_size with its low three bits cleared plus 24. A free request presents
// the object offset and the index found in the block's header; both must agree
// and the index must lie in the pool, else the status is bad address. Every
// result carries the number of blocks in use after the request. A request
// transfer is held in the request register, where the ring lookup, the offset
// arithmetic and the checks are done, and its result is loaded into the result
// register once that is empty or its result is taken. The block accepts one
// request transfer per clock cycle while results are taken; a result that
// waits holds the request register, and req_ready drops once both registers
// are full. The single ring memory port pair is read ahead at the next read
// pointer so that an allocate finds its index ready; a free written in the
// same cycle is forwarded around the memory. Reinitializing needs no clearing
// pass: a high-water mark tells which ring entries were written since the last
// refill, and an entry at or above it reads as its own position.
module fixed_block_pool_allocator_unit
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [OFFSET_W-1:0]   req_obj_offset,
   input  logic [HIDX_W-1:0]     req_header_index,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [BIDX_W-1:0]     rsp_block_index,
   output logic [OFFSET_W-1:0]   rsp_alloc_offset,
   output logic [INUSE_W-1:0]    rsp_in_use_count,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Ring index width and the width of counts that may reach MAX_BLOCKS.
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;
   localparam int HCMP_W = (CNT_W > HIDX_W) ? CNT_W : HIDX_W;

   // Effective pool size for a given block_count value.
   function automatic logic [CNT_W-1:0] eff_count(input logic [BCOUNT_W-1:0] bc);
      logic [CNT_W-1:0] res;
      if (CMP_W'(bc) < CMP_W'(MAX_BLOCKS)) begin
         res = CNT_W'(bc);
      end else begin
         res = CNT_W'(MAX_BLOCKS);
      end
      return res;
   endfunction

   // Ring pointer advance with wrap at the pool size.
   function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] p1;
      logic [IDX_W-1:0] res;
      p1 = CNT_W'(p) + CNT_W'(1);
      if (p1 >= n) begin
         res = '0;
      end else begin
         res = p1[IDX_W-1:0];
      end
      return res;
   endfunction

   // Configuration registers.
   logic [OBJECT_SIZE_W-1:0] object_size_ff, object_size_in;
   logic [BCOUNT_W-1:0]      bcount_ff, bcount_in;

   // Ring control state.
   logic [IDX_W-1:0] rp_ff, rp_in;
   logic [IDX_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] fc_ff, fc_in;
   logic [CNT_W-1:0] mark_ff, mark_in;
   logic             byp_ff, byp_in;
   logic [IDX_W-1:0] byp_data_ff;

   // Request register.
   logic                s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]    s1_cmd_ff;
   logic [OFFSET_W-1:0] s1_off_ff;
   logic [HIDX_W-1:0]   s1_hidx_ff;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BIDX_W-1:0]   rsp_bidx_ff;
   logic [OFFSET_W-1:0] rsp_aoff_ff;
   logic [INUSE_W-1:0]  rsp_inuse_ff;

   // Working signals.
   logic                req_take;
   logic                proc;
   logic                cfg_wr;
   logic [CNT_W-1:0]    n_cnt;
   logic [IDX_W-1:0]    ram_rdata;
   logic [IDX_W-1:0]    ring_word;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_data;
   logic [STRIDE_W-1:0] stride;
   logic [HIDX_W-1:0]   mul_op;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W:0]     offset_sum;
   logic                off_match;
   logic                hidx_ok;
   status_type          res_status;
   logic [BIDX_W-1:0]   res_bidx;
   logic [OFFSET_W-1:0] res_aoff;
   logic [INUSE_W-1:0]  res_inuse;

   assign n_cnt     = eff_count(bcount_ff);
   assign proc      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || proc;
   assign req_take  = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // The ring is read at the next read pointer, so the data is ready in the
   // following cycle for the request that then sits in the request register.
   fbpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_BLOCKS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_addr (rp_in),
      .rd_data (ram_rdata)
   );

   // Entries at or above the mark have not been written since the last refill
   // and still hold their own position.
   always_comb begin
      if (CNT_W'(rp_ff) < mark_ff) begin
         ring_word = byp_ff ? byp_data_ff : ram_rdata;
      end else begin
         ring_word = rp_ff;
      end
   end

   // One shared multiplier: the allocated index for an allocate, the header
   // index for a free check.
   assign stride  = {1'b0, object_size_ff[OBJECT_SIZE_W-1:3], 3'b000} +
                    STRIDE_W'(OVERHEAD_BYTES);
   assign mul_op  = (s1_cmd_ff == CMD_FREE) ? s1_hidx_ff : HIDX_W'(ring_word);
   assign prod    = PROD_W'(mul_op) * PROD_W'(stride);
   assign offset_sum = {1'b0, prod} + (PROD_W + 1)'(HDR_BYTES);
   assign off_match  = (offset_sum == (PROD_W + 1)'(s1_off_ff));
   assign hidx_ok    = HCMP_W'(s1_hidx_ff) < HCMP_W'(n_cnt);
   assign wr_data    = s1_hidx_ff[IDX_W-1:0];

   always_comb begin
      rp_in          = rp_ff;
      wp_in          = wp_ff;
      fc_in          = fc_ff;
      mark_in        = mark_ff;
      object_size_in = object_size_ff;
      bcount_in      = bcount_ff;
      wr_en          = 1'b0;
      res_status     = ST_OK;
      res_bidx       = '0;
      res_aoff       = '0;

      if (proc) begin
         case (cmd_type'(s1_cmd_ff))
            CMD_ALLOC: begin
               if (fc_ff == '0) begin
                  res_status = ST_EXHAUSTED;
               end else begin
                  res_bidx = BIDX_W'(HIDX_W'(ring_word));
                  res_aoff = offset_sum[OFFSET_W-1:0];
                  rp_in    = next_ptr(rp_ff, n_cnt);
                  fc_in    = fc_ff - CNT_W'(1);
                  // Both pointers go home whenever the ring runs empty.
                  if (fc_ff == CNT_W'(1)) begin
                     rp_in = '0;
                     wp_in = '0;
                  end
               end
            end
            CMD_FREE: begin
               if (!(hidx_ok && off_match)) begin
                  res_status = ST_BAD_ADDR;
               end else if (fc_ff >= n_cnt) begin
                  res_status = ST_POOL_FULL;
                  res_bidx   = s1_hidx_ff[BIDX_W-1:0];
               end else begin
                  res_bidx = s1_hidx_ff[BIDX_W-1:0];
                  wr_en    = 1'b1;
                  wp_in    = next_ptr(wp_ff, n_cnt);
                  fc_in    = fc_ff + CNT_W'(1);
                  if ((CNT_W'(wp_ff) + CNT_W'(1)) > mark_ff) begin
                     mark_in = CNT_W'(wp_ff) + CNT_W'(1);
                  end
               end
            end
            CMD_INIT: begin
               rp_in   = '0;
               wp_in   = '0;
               fc_in   = n_cnt;
               mark_in = '0;
            end
            default: begin
            end
         endcase
      end

      // The user must write the registers only while the block is idle; the block itself does not enforce this.
      if (cfg_wr) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_OBJECT_SIZE: begin
               object_size_in = csr_pwdata[OBJECT_SIZE_W-1:0];
            end
            REG_BLOCK_COUNT: begin
               bcount_in = csr_pwdata[BCOUNT_W-1:0];
               rp_in     = '0;
               wp_in     = '0;
               fc_in     = eff_count(csr_pwdata[BCOUNT_W-1:0]);
               mark_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign res_inuse    = INUSE_W'(n_cnt - fc_in);
   assign byp_in       = wr_en && (wp_ff == rp_in);
   assign s1_valid_in  = req_take || (s1_valid_ff && !proc);
   assign rsp_valid_in = proc || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff <= OBJECT_SIZE_RESET;
         bcount_ff      <= BCOUNT_RESET;
         rp_ff          <= '0;
         wp_ff          <= '0;
         fc_ff          <= eff_count(BCOUNT_RESET);
         mark_ff        <= '0;
         byp_ff         <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         object_size_ff <= object_size_in;
         bcount_ff      <= bcount_in;
         rp_ff          <= rp_in;
         wp_ff          <= wp_in;
         fc_ff          <= fc_in;
         mark_ff        <= mark_in;
         byp_ff         <= byp_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= wr_data;
      if (req_take) begin
         s1_cmd_ff  <= req_cmd;
         s1_off_ff  <= req_obj_offset;
         s1_hidx_ff <= req_header_index;
      end
      if (proc) begin
         rsp_status_ff <= res_status;
         rsp_bidx_ff   <= res_bidx;
         rsp_aoff_ff   <= res_aoff;
         rsp_inuse_ff  <= res_inuse;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_index  = rsp_bidx_ff;
   assign rsp_alloc_offset = rsp_aoff_ff;
   assign rsp_in_use_count = rsp_inuse_ff;

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_OBJECT_SIZE: csr_prdata = CSR_DATA_W'(object_size_ff);
         REG_BLOCK_COUNT: csr_prdata = CSR_DATA_W'(bcount_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // The free count never exceeds the pool size.
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= n_cnt)
      else $error("free count above pool size");

   // The written region never reaches past the pool.
   a_mark_bound: assert property (@(posedge clock) disable iff (reset)
      mark_ff <= n_cnt)
      else $error("ring high-water mark above pool size");

   // An empty ring always has both pointers at zero.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fc_ff == '0) |-> (rp_ff == '0 && wp_ff == '0))
      else $error("pointers not home on empty ring");

   // While blocks are free, the read pointer lies inside the pool.
   a_rp_range: assert property (@(posedge clock) disable iff (reset)
      (fc_ff != '0) |-> (CNT_W'(rp_ff) < n_cnt))
      else $error("read pointer outside pool");

   // A successful allocate takes exactly one block off the free count.
   a_alloc_dec: assert property (@(posedge clock) disable iff (reset)
      (proc && s1_cmd_ff == CMD_ALLOC && res_status == ST_OK)
         |=> (fc_ff == $past(fc_ff) - CNT_W'(1)))
      else $error("allocate did not decrement free count");

endmodule

>>> src/fbpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
